/* rtl/core/trf_pkg.sv */
package trf_pkg;

  // Default sizing, handed to the top level parameters.
  localparam int MaxRecordDef  = 8192;
  localparam int BlockBytesDef = 512;

  // One input beat produces at most this many output beats.
  localparam int MaxResults = 4;
  localparam int CntW       = $clog2(MaxResults + 1);
  localparam int IdxW       = $clog2(MaxResults);

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [1:0] MODE_ASCII     = 2'd0;
  localparam logic [1:0] MODE_BINARY    = 2'd1;
  localparam logic [1:0] MODE_FORMATTED = 2'd2;
  // The unused mode code; the framer treats it as unformatted binary.
  localparam logic [1:0] MODE_SPARE     = 2'd3;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_NOP   = 2'd3
  } trf_cmd_t;

  // The output beats caused by one input beat, with their block-end flags.
  typedef struct packed {
    logic [CntW-1:0]             cnt;
    logic [MaxResults-1:0]       ends;
    logic [MaxResults-1:0][7:0]  bytes;
  } trf_bundle_t;

endpackage

/* rtl/core/trf_in_if.sv */
interface trf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  data_byte;
  logic [13:0] record_length;

  modport source (output valid, output cmd, output data_byte, output record_length,
                  input ready);
  modport sink (input valid, input cmd, input data_byte, input record_length,
                output ready);
endinterface

/* rtl/core/trf_out_if.sv */
interface trf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       block_end;
  logic       last_of_run;

  modport source (output valid, output out_byte, output block_end, output last_of_run,
                  input ready);
  modport sink (input valid, input out_byte, input block_end, input last_of_run,
                output ready);
endinterface

/* rtl/core/trf_decode.sv */
module trf_decode
  import trf_pkg::*;
#(
  parameter int MAX_RECORD  = MaxRecordDef,
  parameter int BLOCK_BYTES = BlockBytesDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_wdata,
  trf_in_if.sink       in_chan,
  input  logic         ser_rdy,
  output logic         ld_valid,
  output trf_bundle_t  bun
);

  localparam int PW = (BLOCK_BYTES > 2) ? $clog2(BLOCK_BYTES) : 1;
  localparam int RW = $clog2(MAX_RECORD + 1);

  logic              ir_vld_r;
  trf_cmd_t          ir_cmd_r;
  logic [7:0]        ir_db_r;
  logic [13:0]       ir_len_r;
  logic [1:0]        mode_r;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [RW-1:0]     rem_r, rem_nxt;
  logic              even_r, even_nxt;
  logic              take;
  logic [16:0]       len_w, len_sat, total_w;
  logic [7:0]        sum_d;
  logic [PW-1:0]     p [0:MaxResults];

  assign len_w   = {3'b000, ir_len_r};
  assign len_sat = (len_w > 17'(MAX_RECORD)) ? 17'(MAX_RECORD) : len_w;
  assign total_w = len_sat + 17'd4;
  assign sum_d   = sum_r + ir_db_r;

  always_comb begin
    bun      = '0;
    sum_nxt  = sum_r;
    rem_nxt  = rem_r;
    even_nxt = even_r;
    case (ir_cmd_r)
      CMD_START: begin
        if (mode_r == MODE_FORMATTED && rem_r == '0 && ir_len_r != '0) begin
          bun.cnt   = CntW'(4);
          bun.bytes = {total_w[15:8], total_w[7:0], 8'h00, 8'h01};
          sum_nxt   = 8'd1 + total_w[7:0] + total_w[15:8];
          rem_nxt   = len_sat[RW-1:0];
          even_nxt  = ~len_sat[0];
        end
      end
      CMD_DATA: begin
        if (mode_r == MODE_ASCII) begin
          if (ir_db_r == CH_LF) begin
            bun.cnt      = CntW'(2);
            bun.bytes[0] = CH_CR;
            bun.bytes[1] = ir_db_r;
          end else begin
            bun.cnt      = CntW'(1);
            bun.bytes[0] = ir_db_r;
          end
        end else if (mode_r == MODE_FORMATTED) begin
          if (rem_r != '0) begin
            bun.bytes[0] = ir_db_r;
            rem_nxt      = rem_r - RW'(1);
            if (rem_r == RW'(1)) begin
              // Record closes: checksum byte, then a pad zero for even lengths.
              bun.cnt      = even_r ? CntW'(3) : CntW'(2);
              bun.bytes[1] = 8'h00 - sum_d;
              sum_nxt      = 8'h00;
              even_nxt     = 1'b0;
            end else begin
              bun.cnt = CntW'(1);
              sum_nxt = sum_d;
            end
          end
        end else begin
          bun.cnt      = CntW'(1);
          bun.bytes[0] = ir_db_r;
        end
      end
      CMD_FLUSH: begin
        if (pos_r != '0) begin
          bun.cnt = CntW'(1);
        end
      end
      default: ;
    endcase

    // Walk the block position across the beats of this bundle.
    p[0] = pos_r;
    for (int k = 0; k < MaxResults; k++) begin
      bun.ends[k] = (p[k] == PW'(BLOCK_BYTES - 1));
      p[k+1]      = bun.ends[k] ? '0 : p[k] + PW'(1);
    end
    case (bun.cnt)
      CntW'(1): pos_nxt = p[1];
      CntW'(2): pos_nxt = p[2];
      CntW'(3): pos_nxt = p[3];
      CntW'(4): pos_nxt = p[4];
      default:  pos_nxt = p[0];
    endcase
  end

  assign take          = ir_vld_r && (bun.cnt == '0 || ser_rdy);
  assign ld_valid      = ir_vld_r && bun.cnt != '0;
  assign in_chan.ready = !ir_vld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_vld_r <= 1'b0;
      mode_r   <= MODE_BINARY;
      pos_r    <= '0;
      sum_r    <= '0;
      rem_r    <= '0;
      even_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (in_chan.ready) begin
        ir_vld_r <= in_chan.valid;
      end
      if (take) begin
        pos_r  <= pos_nxt;
        sum_r  <= sum_nxt;
        rem_r  <= rem_nxt;
        even_r <= even_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      ir_cmd_r <= trf_cmd_t'(in_chan.cmd);
      ir_db_r  <= in_chan.data_byte;
      ir_len_r <= in_chan.record_length;
    end
  end

endmodule

/* rtl/core/trf_serializer.sv */
module trf_serializer
  import trf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         ld_valid,
  input  trf_bundle_t  bun,
  output logic         ser_rdy,
  trf_out_if.source    out_chan
);

  logic             vld_r;
  logic [IdxW-1:0]  idx_r;
  trf_bundle_t      bun_r;
  logic             last;
  logic             load;

  assign last    = ({1'b0, idx_r} == bun_r.cnt - CntW'(1));
  assign ser_rdy = !vld_r || (out_chan.ready && last);
  assign load    = ld_valid && ser_rdy;

  assign out_chan.valid       = vld_r;
  assign out_chan.out_byte    = bun_r.bytes[idx_r];
  assign out_chan.block_end   = bun_r.ends[idx_r];
  assign out_chan.last_of_run = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else if (load) begin
      vld_r <= 1'b1;
      idx_r <= '0;
    end else if (vld_r && out_chan.ready) begin
      if (last) begin
        vld_r <= 1'b0;
      end else begin
        idx_r <= idx_r + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bun_r <= bun;
    end
  end

endmodule

/* rtl/core/tape_record_framer_core.sv */
// Tape record framer. Each input beat is a command (start record, data byte or
// flush step) and produces zero to four output bytes on the result channel, which
// are counted into tape blocks of BLOCK_BYTES bytes; block_end marks the byte that
// fills a block and last_of_run marks the final byte caused by one input beat. The
// mode register selects ASCII (a CR is inserted before every LF), unformatted
// binary (bytes pass through, also for mode three) or formatted binary, where a
// start command opens a record of record_length data bytes (saturated at
// MAX_RECORD), framed by the bytes 1 and 0, the length plus four low byte first,
// the data, a two's-complement checksum and a pad zero for even lengths. The block
// accepts one input beat per cycle while the serializer can take its bundle and
// emits one output beat per cycle while the output is ready: an input beat that
// causes n output bytes holds the serializer until its last byte is taken, so
// throughput is set by the output serializer at one byte per clock. Commands with
// no bytes (a start outside formatted mode, with zero length or in an open record,
// data with no open record, a flush at position zero, command three) are absorbed
// without waiting for the output. Bytes pass the input, then the result register.
// Write the mode register only while the block is idle.
module tape_record_framer_core
  import trf_pkg::*;
#(
  parameter int MAX_RECORD  = MaxRecordDef,
  parameter int BLOCK_BYTES = BlockBytesDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  trf_in_if.sink     in_chan,
  trf_out_if.source  out_chan
);

  // Decoded bundle handed from the expansion stage to the output serializer.
  logic        ld_valid;
  logic        ser_rdy;
  trf_bundle_t bun;

  // Input register, mode register, framing state and byte expansion.
  trf_decode #(
    .MAX_RECORD  (MAX_RECORD),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .ser_rdy   (ser_rdy),
    .ld_valid  (ld_valid),
    .bun       (bun)
  );

  // Result register that plays out one bundle a beat at a time.
  trf_serializer u_ser (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld_valid (ld_valid),
    .bun      (bun),
    .ser_rdy  (ser_rdy),
    .out_chan (out_chan)
  );

  // A bundle handed to the serializer always carries at least one byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    ld_valid |-> bun.cnt != '0)
    else $error("empty bundle offered to serializer");

  // Within one run the bytes follow without a gap.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.ready && !out_chan.last_of_run |=> out_chan.valid)
    else $error("gap inside an output run");

  // The input side stalls only while the output cannot take a new bundle.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> ld_valid && !ser_rdy)
    else $error("input stalled without output back-pressure");

endmodule
